>>> rtl/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Clocked assertion shorthands used by the list engine top module.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// check on every rising edge, disabled while reset is held
`define PLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define PLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Command and status codes, field widths and the cell control type.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CNT_OUT_W = 7;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic do_insert;
        logic do_delete;
    } ple_ctrl_t;

endpackage

>>> rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered byte sequence edited by position through a row of shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (in_valid/in_ready): command, position, new_byte.
//   Result channel (out_valid/out_ready): item_byte, item_count,
//   is_empty_flag, status; exactly one result per command, in order.
//   Insert, delete and read all complete in the cell row on the cycle the
//   command is taken: every cell shifts toward or away from its neighbor
//   at once, so one command per cycle is sustained unless the receiver stalls.
//   On the way to the result, the byte is registered first in the grouped
//   read taps (up to 32 cells per group), then in the result register
//   after the final merge.
//   Bad positions and inserts into a full list report a status code and
//   leave the sequence untouched.
//   Reset empties the list (count zero); cell contents are not cleared and
//   need no clearing pass.
//   When the receiver stalls, the result register and the middle stage
//   hold; in_ready drops once both are occupied.
// ----------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ple_pkg::CMD_W-1:0]     command,
    input  logic [ple_pkg::POS_W-1:0]     position,
    input  logic [ple_pkg::BYTE_W-1:0]    new_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ple_pkg::BYTE_W-1:0]    item_byte,
    output logic [ple_pkg::CNT_OUT_W-1:0] item_count,
    output logic                          is_empty_flag,
    output logic [ple_pkg::ST_W-1:0]      status
);
    import ple_pkg::*;

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP_SIZE = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD        = GROUPS * GROUP_SIZE;

    logic                  in_fire;
    logic                  adv_out;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  full;
    logic                  ins_ok;
    logic                  del_ok;
    logic                  rd_ok;
    logic [ST_W-1:0]       status_next;
    ple_ctrl_t             ctrl;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CMP_W-1:0]      count_next_ext;

    logic [BYTE_W-1:0]     cell_data [CAPACITY];
    logic [BYTE_W-1:0]     cell_rd [PAD];
    logic [BYTE_W-1:0]     grp_byte [GROUPS];
    logic [BYTE_W-1:0]     merged_byte;

    logic                  s1_valid_reg;
    logic                  s1_byte_en_reg;
    logic [CNT_OUT_W-1:0]  s1_count_reg;
    logic                  s1_empty_reg;
    logic [ST_W-1:0]       s1_status_reg;

    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic [CNT_OUT_W-1:0]  out_count_reg;
    logic                  out_empty_reg;
    logic [ST_W-1:0]       out_status_reg;

    assign adv_out  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv_out;
    assign in_fire  = in_valid && in_ready;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        rd_ok       = 1'b0;
        status_next = ST_OK;
        case (command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    del_ok = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_next_ext = CMP_W'(count_next);

    assign ctrl.do_insert = in_fire && ins_ok;
    assign ctrl.do_delete = in_fire && del_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [BYTE_W-1:0] left_byte;
        logic [BYTE_W-1:0] right_byte;

        if (i == 0)
        begin : g_first
            assign left_byte = '0;
        end
        else
        begin : g_mid_l
            assign left_byte = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_byte = '0;
        end
        else
        begin : g_mid_r
            assign right_byte = cell_data[i+1];
        end

        ple_cell #(
            .CMP_W (CMP_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (pos_ext),
            .idx        (CMP_W'(i)),
            .new_byte   (new_byte),
            .left_byte  (left_byte),
            .right_byte (right_byte),
            .data       (cell_data[i]),
            .rd_byte    (cell_rd[i])
        );
    end

    for (genvar i = CAPACITY; i < PAD; i++)
    begin : g_pad
        assign cell_rd[i] = '0;
    end

    for (genvar g = 0; g < GROUPS; g++)
    begin : g_group
        logic [BYTE_W-1:0] taps [GROUP_SIZE];

        for (genvar k = 0; k < GROUP_SIZE; k++)
        begin : g_tap
            assign taps[k] = cell_rd[g*GROUP_SIZE + k];
        end

        ple_group #(
            .N (GROUP_SIZE)
        ) u_group (
            .clk      (clk),
            .en       (in_fire),
            .taps     (taps),
            .sel_byte (grp_byte[g])
        );
    end

    always_comb
    begin
        merged_byte = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            merged_byte = merged_byte | grp_byte[g];
        end
        if (!s1_byte_en_reg)
        begin
            merged_byte = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv_out)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_en_reg <= del_ok || rd_ok;
            s1_count_reg   <= count_next_ext[CNT_OUT_W-1:0];
            s1_empty_reg   <= (count_next == '0);
            s1_status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && s1_valid_reg)
        begin
            out_byte_reg   <= merged_byte;
            out_count_reg  <= s1_count_reg;
            out_empty_reg  <= s1_empty_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign item_byte     = out_byte_reg;
    assign item_count    = out_count_reg;
    assign is_empty_flag = out_empty_reg;
    assign status        = out_status_reg;

    `PLE_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PLE_ASSERT(a_count_hold, !in_fire |=> $stable(count_reg), "count moved without an item")
    `PLE_ASSERT(a_insert_grow, in_fire && ins_ok |=> (count_reg - $past(count_reg)) == CNT_W'(1), "insert did not grow count")
    `PLE_ASSERT(a_stage_hold, s1_valid_reg && !in_ready |=> s1_valid_reg && $stable(s1_status_reg), "middle stage lost item")

endmodule

>>> rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list engine storage cell
// Holds one byte of the sequence; shifts with its neighbors on insert and
// delete and offers its byte when its index matches the position.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int CMP_W = 7
) (
    input  logic                     clk,
    input  ple_pkg::ple_ctrl_t       ctrl,
    input  logic [CMP_W-1:0]         pos,
    input  logic [CMP_W-1:0]         idx,
    input  logic [ple_pkg::BYTE_W-1:0] new_byte,
    input  logic [ple_pkg::BYTE_W-1:0] left_byte,
    input  logic [ple_pkg::BYTE_W-1:0] right_byte,
    output logic [ple_pkg::BYTE_W-1:0] data,
    output logic [ple_pkg::BYTE_W-1:0] rd_byte
);
    import ple_pkg::*;

    logic              at_pos;
    logic              past_pos;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    assign at_pos   = (idx == pos);
    assign past_pos = (idx > pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.do_insert)
        begin
            if (past_pos)
            begin
                data_next = left_byte;
            end
            else if (at_pos)
            begin
                data_next = new_byte;
            end
        end
        else if (ctrl.do_delete)
        begin
            if (past_pos || at_pos)
            begin
                data_next = right_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_byte = at_pos ? data_reg : '0;

endmodule

>>> rtl/ple_group.sv
// ----------------------------------------------------------------------------
// Positional list engine read group
// Merges the read taps of one group of cells into a registered byte.
// ----------------------------------------------------------------------------
module ple_group #(
    parameter int N = 32
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ple_pkg::BYTE_W-1:0] taps [N],
    output logic [ple_pkg::BYTE_W-1:0] sel_byte
);
    import ple_pkg::*;

    logic [BYTE_W-1:0] sel_byte_reg;
    logic [BYTE_W-1:0] sel_byte_next;

    always_comb
    begin
        sel_byte_next = '0;
        for (int k = 0; k < N; k++)
        begin
            sel_byte_next = sel_byte_next | taps[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_byte_reg <= sel_byte_next;
        end
    end

    assign sel_byte = sel_byte_reg;

endmodule

>>> bench/tb_positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, delete and read commands, including bad positions, full-list
// inserts and the unused command code. Both channels idle at random. A
// scoreboard keeps its own copy of the byte sequence, predicts every result
// and compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASE_LEN    = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_HOLD    = 300;

    localparam logic [POS_W-1:0] MAX_POS    = 7'd127;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        PHASE_GROW,
        PHASE_SHRINK,
        PHASE_MIXED
    } list_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    item_byte;
        logic [CNT_OUT_W-1:0] item_count;
        logic                 is_empty_flag;
        logic [ST_W-1:0]      status;
    } list_result_t;

    class list_scoreboard;
        logic [BYTE_W-1:0] held_bytes [CAPACITY];
        int unsigned       fill = 0;
        list_result_t      awaited [$];
        int unsigned       accepted = 0;
        int unsigned       checked = 0;
        int unsigned       mismatches = 0;
        int unsigned       peak_fill = 0;
        int unsigned       full_rejects = 0;
        int unsigned       range_rejects = 0;

        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [BYTE_W-1:0] nb);
            list_result_t res;
            int unsigned  idx;
            res = '0;
            res.status = ST_OK;
            accepted++;
            case (cmd)
                CMD_INSERT:
                begin
                    if (fill >= CAPACITY)
                        res.status = ST_FULL;
                    else if (pos > fill)
                        res.status = ST_RANGE;
                    else
                    begin
                        for (idx = fill; idx > pos; idx--)
                            held_bytes[idx] = held_bytes[idx-1];
                        held_bytes[pos] = nb;
                        fill++;
                    end
                end
                CMD_DELETE:
                begin
                    if (pos >= fill)
                        res.status = ST_RANGE;
                    else
                    begin
                        res.item_byte = held_bytes[pos];
                        for (idx = pos; idx + 1 < fill; idx++)
                            held_bytes[idx] = held_bytes[idx+1];
                        fill--;
                    end
                end
                CMD_READ:
                begin
                    if (pos >= fill)
                        res.status = ST_RANGE;
                    else
                        res.item_byte = held_bytes[pos];
                end
                default:
                begin
                end
            endcase
            if (res.status == ST_FULL)
                full_rejects++;
            if (res.status == ST_RANGE)
                range_rejects++;
            if (fill > peak_fill)
                peak_fill = fill;
            res.item_count    = CNT_OUT_W'(fill);
            res.is_empty_flag = (fill == 0);
            awaited.push_back(res);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: byte %02h count %0d empty %0b status %0d",
                             got.item_byte, got.item_count, got.is_empty_flag, got.status);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d mismatch: expected byte %02h count %0d empty %0b ",
                              "status %0d, got byte %02h count %0d empty %0b status %0d"},
                             checked, want.item_byte, want.item_count, want.is_empty_flag,
                             want.status, got.item_byte, got.item_count, got.is_empty_flag,
                             got.status);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      command = CMD_INSERT;
    logic [POS_W-1:0]      position = '0;
    logic [BYTE_W-1:0]     new_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BYTE_W-1:0]     item_byte;
    logic [CNT_OUT_W-1:0]  item_count;
    logic                  is_empty_flag;
    logic [ST_W-1:0]       status;

    list_scoreboard sb;
    bit             sender_steady = 1'b0;
    int unsigned    cycle_count = 0;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .position(position),
        .new_byte(new_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .item_byte(item_byte),
        .item_count(item_count),
        .is_empty_flag(is_empty_flag),
        .status(status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d results outstanding", sb.awaited.size());
            $display("positional_list_engine test failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void pick_command(input list_phase_t phase,
                                         output logic [CMD_W-1:0] cmd,
                                         output logic [POS_W-1:0] pos,
                                         output logic [BYTE_W-1:0] nb);
        int unsigned roll;
        int unsigned fill;
        int unsigned ins_pct;
        int unsigned del_pct;
        fill = sb.fill;
        case (phase)
            PHASE_GROW:
            begin
                ins_pct = 75;
                del_pct = 10;
            end
            PHASE_SHRINK:
            begin
                ins_pct = 15;
                del_pct = 65;
            end
            default:
            begin
                ins_pct = 40;
                del_pct = 30;
            end
        endcase
        nb = BYTE_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 2)
            cmd = CMD_UNUSED;
        else if (roll < 2 + ins_pct)
            cmd = CMD_INSERT;
        else if (roll < 2 + ins_pct + del_pct)
            cmd = CMD_DELETE;
        else
            cmd = CMD_READ;
        roll = $urandom_range(0, 99);
        if (cmd == CMD_INSERT)
            pos = (roll < 90) ? POS_W'($urandom_range(0, fill))
                              : POS_W'($urandom_range(fill + 1, MAX_POS));
        else if (roll < 90 && fill > 0)
            pos = POS_W'($urandom_range(0, fill - 1));
        else
            pos = POS_W'($urandom_range(fill, MAX_POS));
    endfunction

    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic [BYTE_W-1:0] nb);
        in_valid <= 1'b1;
        command  <= cmd;
        position <= pos;
        new_byte <= nb;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(cmd, pos, nb);
    endtask

    task automatic idle_after(input int unsigned gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic step(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                        input logic [BYTE_W-1:0] nb);
        offer_command(cmd, pos, nb);
        idle_after(sender_steady ? 0 : pick_gap());
    endtask

    initial
    begin : result_side
        int unsigned stall_left;
        int unsigned rx_cycle;
        bit          long_hold_done;
        bit          steady;
        stall_left     = 0;
        rx_cycle       = 0;
        long_hold_done = 1'b0;
        steady         = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (out_valid && out_ready)
                sb.check_result(list_result_t'({item_byte, item_count, is_empty_flag, status}));
            if (!long_hold_done && sb.checked >= 500)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            if (rx_cycle % 300 == 0)
                steady = ~steady;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : command_side
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] nb;
        list_phase_t       phase;
        int unsigned       n;
        sb = new;
        phase = PHASE_GROW;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list and edge positions
        step(CMD_READ,   7'd0,    8'h00);
        step(CMD_DELETE, 7'd0,    8'h00);
        step(CMD_INSERT, 7'd1,    8'h11);
        step(CMD_UNUSED, 7'd0,    8'h00);
        step(CMD_INSERT, 7'd0,    8'h00);
        step(CMD_INSERT, 7'd1,    8'hFF);
        step(CMD_INSERT, 7'd1,    8'hA5);
        step(CMD_INSERT, 7'd0,    8'h5A);
        step(CMD_READ,   7'd0,    8'h00);
        step(CMD_READ,   7'd1,    8'h00);
        step(CMD_READ,   7'd2,    8'h00);
        step(CMD_READ,   7'd3,    8'hFF);
        step(CMD_READ,   7'd4,    8'h00);
        step(CMD_READ,   MAX_POS, 8'h00);
        step(CMD_INSERT, MAX_POS, 8'hFF);
        step(CMD_DELETE, MAX_POS, 8'h00);
        step(CMD_UNUSED, MAX_POS, 8'hFF);
        step(CMD_DELETE, 7'd1,    8'h00);
        step(CMD_DELETE, 7'd2,    8'h00);
        step(CMD_DELETE, 7'd0,    8'h00);
        step(CMD_DELETE, 7'd0,    8'h00);
        step(CMD_READ,   7'd0,    8'h00);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                if (n == 0)
                    phase = PHASE_GROW;
                else if (n == PHASE_LEN)
                    phase = PHASE_SHRINK;
                else
                    phase = list_phase_t'($urandom_range(0, 2));
            end
            if (n % 100 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            pick_command(phase, cmd, pos, nb);
            offer_command(cmd, pos, nb);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            else
                idle_after(sender_steady ? 0 : pick_gap());
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands, checked %0d results, peak fill %0d of %0d",
                 sb.accepted, sb.checked, sb.peak_fill, CAPACITY);
        $display("rejected %0d full-list inserts and %0d out-of-range positions, %0d mismatches",
                 sb.full_rejects, sb.range_rejects, sb.mismatches);
        if (sb.awaited.size() != 0)
            $display("%0d results never arrived", sb.awaited.size());
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("positional_list_engine test passed");
        else
            $display("positional_list_engine test failed");
        $finish;
    end
endmodule
